// ----- src/ipp_pkg.sv -----
// Shared types, constants and the control store of the incremental PID position loop.
// No dependencies; every other file imports it.
package ipp_pkg;

	// Port widths
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 40;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;

	// Divider digit width and the reciprocal of five for an 11-bit partial dividend
	localparam int          DIG_W     = 8;
	localparam logic [11:0] RECIP5    = 12'd3277;
	localparam int          RECIP5_SH = 14;

	// Register reset values
	localparam logic [7:0]  DEAD_BAND_RST = 8'd3;
	localparam logic [15:0] INT_LIMIT_RST = 16'd80;
	localparam logic [15:0] CENTER_RST    = 16'd1680;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AIM       = 3'd0,
		REG_GAIN_P    = 3'd1,
		REG_GAIN_I    = 3'd2,
		REG_GAIN_D    = 3'd3,
		REG_DEAD_BAND = 3'd4,
		REG_INT_LIMIT = 3'd5,
		REG_CENTER    = 3'd6
	} cfg_reg_t;

	// Datapath operations, one per control word
	typedef enum logic [3:0] {
		OP_IDLE, // wait for an item
		OP_ERR,  // error and deadband
		OP_MD,   // gain_d product, clamp the average
		OP_MP,   // filter numerator part one, gain_p product
		OP_MI,   // filter numerator part two, gain_i product
		OP_DV0,  // fold integral term, set up the divider
		OP_DIV,  // one quotient byte
		OP_FD,   // store the filtered derivative
		OP_INC,  // add derivative to the increment
		OP_ACC,  // update accumulator and error history
		OP_OUT   // load the result register
	} op_t;

	// Sequencing of the step counter
	typedef enum logic [1:0] {
		J_NEXT, // advance
		J_TAKE, // on an item: advance if seen, else jump
		J_LOOP, // jump until the last divider step, then advance
		J_OUT   // jump once the result register is free
	} jmp_t;

	localparam int PC_W = 4;
	typedef logic [PC_W-1:0] pc_t;

	localparam pc_t PC_IDLE = 4'd0;
	localparam pc_t PC_ERR  = 4'd1;
	localparam pc_t PC_MD   = 4'd2;
	localparam pc_t PC_MP   = 4'd3;
	localparam pc_t PC_MI   = 4'd4;
	localparam pc_t PC_DV0  = 4'd5;
	localparam pc_t PC_DIV  = 4'd6;
	localparam pc_t PC_FD   = 4'd7;
	localparam pc_t PC_INC  = 4'd8;
	localparam pc_t PC_ACC  = 4'd9;
	localparam pc_t PC_OUT  = 4'd10;

	typedef struct packed {
		op_t  op;
		jmp_t jmp;
		pc_t  target;
	} uword_t;

	// Status the sequencer branches on
	typedef struct packed {
		logic take;
		logic seen;
		logic div_last;
		logic out_free;
	} seq_stat_t;

	// Control store
	function automatic uword_t ucode(pc_t pc);
		uword_t w;
		case (pc)
			PC_IDLE: w = '{OP_IDLE, J_TAKE, PC_OUT};
			PC_ERR:  w = '{OP_ERR,  J_NEXT, PC_IDLE};
			PC_MD:   w = '{OP_MD,   J_NEXT, PC_IDLE};
			PC_MP:   w = '{OP_MP,   J_NEXT, PC_IDLE};
			PC_MI:   w = '{OP_MI,   J_NEXT, PC_IDLE};
			PC_DV0:  w = '{OP_DV0,  J_NEXT, PC_IDLE};
			PC_DIV:  w = '{OP_DIV,  J_LOOP, PC_DIV};
			PC_FD:   w = '{OP_FD,   J_NEXT, PC_IDLE};
			PC_INC:  w = '{OP_INC,  J_NEXT, PC_IDLE};
			PC_ACC:  w = '{OP_ACC,  J_NEXT, PC_IDLE};
			PC_OUT:  w = '{OP_OUT,  J_OUT,  PC_IDLE};
			default: w = '{OP_IDLE, J_OUT,  PC_IDLE};
		endcase
		return w;
	endfunction

	// Quotient of an 11-bit partial dividend (below 5 * 256) by five
	function automatic logic [DIG_W-1:0] div5_digit(logic [DIG_W+2:0] v);
		logic [DIG_W+14:0] p;
		p = {12'd0, v} * {11'd0, RECIP5};
		return p[RECIP5_SH +: DIG_W];
	endfunction

endpackage

// ----- src/incremental_pid_position.sv -----
// Top level of the incremental PID position loop: registers, datapath, result register.
// Depends on ipp_pkg and ipp_seq.
//
// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+-------------------------------------
// s_axis   | in        | tvalid / tready         | tuser: target_seen; tdata: position
// m_axis   | out       | tvalid / tready         | tuser: updated; tdata: drive, error
// cfg      | in        | cfg_we (no wait)        | cfg_index, cfg_data
//
// An update item steps through the error, the three products, the byte-serial divide
// by five in the derivative filter, the filter store, the increment and the accumulator
// update before its result is loaded; a hold item goes from accept straight to the load
// of its result. The shared multiplier runs three times.
// Reset clears the configuration registers and loop state to their reset values and loads
// the accumulator with the center value. A stalled output holds the sequencer in its last
// step; input is taken again as soon as the result register has been loaded.
module incremental_pid_position import ipp_pkg::*; #(
	parameter int GAIN_FRAC_BITS = 8,
	parameter int ACC_FRAC_BITS  = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [15:0] measured_position
	input  logic                   s_axis_tuser,  // [0] target_seen
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [15:0] drive_value, [32:16] error_used
	output logic                   m_axis_tuser,  // [0] updated
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int A       = ACC_FRAC_BITS;
	localparam int G       = GAIN_FRAC_BITS;
	localparam int ACC_W   = 24 + A;
	localparam int DER_W   = 32 + A;
	localparam int PROD_W  = 36;
	localparam int SHL_G   = (A >= G) ? A - G : 0;
	localparam int SHR_G   = (A >= G) ? 0 : G - A;
	localparam int SHL_I   = (A >= G + 1) ? A - G - 1 : 0;
	localparam int SHR_I   = (A >= G + 1) ? 0 : G + 1 - A;
	localparam int W_A     = PROD_W + 1 + SHL_G;
	localparam int W_B     = DER_W + 2;
	localparam int W_RAW   = ((W_A > W_B) ? W_A : W_B) + 2;
	localparam int W       = ((W_RAW + DIG_W - 1) / DIG_W) * DIG_W;
	localparam int DIV_STEPS = W / DIG_W;
	localparam int CNT_W   = $clog2(DIV_STEPS);

	// Configuration registers
	logic [15:0] aim_q, gain_p_q, gain_i_q, gain_d_q, limit_q;
	logic [7:0]  db_q;

	// Loop state
	logic signed [16:0]      last_q, prior_q;
	logic signed [DER_W-1:0] fd_q;
	logic signed [ACC_W-1:0] acc_q;

	// Working registers
	logic [15:0]              meas_q;
	logic                     seen_q;
	logic signed [16:0]       err_q;
	logic signed [17:0]       avg_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [W-1:0]      sum_q, inc_q;
	logic [2:0]               rem_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     neg_q;

	// Result register
	logic                   m_valid_q;
	logic [OUT_TDATA_W-1:0] m_data_q;
	logic                   m_user_q;

	op_t       op;
	seq_stat_t stat;
	logic      take, out_free;

	assign s_axis_tready = (op == OP_IDLE);
	assign take          = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;

	assign stat.take     = take;
	assign stat.seen     = s_axis_tuser;
	assign stat.div_last = (cnt_q == CNT_W'(DIV_STEPS - 1));
	assign stat.out_free = out_free;

	ipp_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.op     (op)
	);

	// Error with deadband
	logic signed [16:0] diff_raw, err_dz;
	logic [16:0]        mag;
	assign diff_raw = $signed({1'b0, meas_q}) - $signed({1'b0, aim_q});
	assign mag      = diff_raw[16] ? 17'(-diff_raw) : 17'(diff_raw);
	assign err_dz   = (mag < {9'd0, db_q}) ? 17'sd0 : diff_raw;

	// Clamped average (Q.1) and differences
	logic signed [17:0] avg_raw, lim2, avg_cl, de;
	logic signed [18:0] diff2;
	assign avg_raw = {err_q[16], err_q} + {last_q[16], last_q};
	assign lim2    = $signed({1'b0, limit_q, 1'b0});
	always_comb begin
		avg_cl = avg_raw;
		if (avg_raw > lim2) begin
			avg_cl = lim2;
		end else if (avg_raw < -lim2) begin
			avg_cl = -lim2;
		end
	end
	assign de    = {err_q[16], err_q} - {last_q[16], last_q};
	assign diff2 = {{2{err_q[16]}}, err_q} - {last_q[16], last_q, 1'b0}
		+ {{2{prior_q[16]}}, prior_q};

	// Shared multiplier
	logic [15:0]              mul_a;
	logic signed [18:0]       mul_b;
	logic signed [PROD_W-1:0] product;
	always_comb begin
		case (op)
			OP_MP: begin
				mul_a = gain_p_q;
				mul_b = {de[17], de};
			end
			OP_MI: begin
				mul_a = gain_i_q;
				mul_b = {avg_q[17], avg_q};
			end
			default: begin
				mul_a = gain_d_q;
				mul_b = diff2;
			end
		endcase
	end
	assign product = $signed({1'b0, mul_a}) * mul_b;

	// Rescale products to the accumulator fraction
	logic signed [W-1:0] prod_w, g_term, i_term, fd_w, acc_w;
	assign prod_w = {{(W - PROD_W){prod_q[PROD_W-1]}}, prod_q};
	assign g_term = (prod_w <<< SHL_G) >>> SHR_G;
	assign i_term = (prod_w <<< SHL_I) >>> SHR_I;
	assign fd_w   = {{(W - DER_W){fd_q[DER_W-1]}}, fd_q};
	assign acc_w  = {{(W - ACC_W){acc_q[ACC_W-1]}}, acc_q};

	// One quotient byte of the divide by five
	logic [DIG_W+2:0] dig_in, rem_full;
	logic [DIG_W-1:0] qd;
	assign dig_in   = {rem_q, sum_q[W-1 -: DIG_W]};
	assign qd       = div5_digit(dig_in);
	assign rem_full = dig_in - ({3'd0, qd} * 11'd5);

	// Floor quotient and saturation of the filter
	logic signed [W-1:0]     q_s, acc_sum;
	logic signed [DER_W-1:0] fd_sat;
	logic signed [ACC_W-1:0] acc_sat;
	assign q_s = neg_q ? ~sum_q : sum_q;
	always_comb begin
		if ((&q_s[W-1:DER_W-1]) || !(|q_s[W-1:DER_W-1])) begin
			fd_sat = q_s[DER_W-1:0];
		end else begin
			fd_sat = {q_s[W-1], {(DER_W - 1){~q_s[W-1]}}};
		end
	end

	// Accumulator update with saturation
	assign acc_sum = acc_w + inc_q;
	always_comb begin
		if ((&acc_sum[W-1:ACC_W-1]) || !(|acc_sum[W-1:ACC_W-1])) begin
			acc_sat = acc_sum[ACC_W-1:0];
		end else begin
			acc_sat = {acc_sum[W-1], {(ACC_W - 1){~acc_sum[W-1]}}};
		end
	end

	// Drive value: integer part, saturated to 16 bits unsigned
	logic [15:0]        drive;
	logic signed [16:0] err_out;
	always_comb begin
		if (acc_q[ACC_W-1]) begin
			drive = 16'd0;
		end else if (|acc_q[ACC_W-2:A+16]) begin
			drive = 16'hFFFF;
		end else begin
			drive = acc_q[A+15:A];
		end
	end
	assign err_out = seen_q ? err_q : 17'sd0;

	// Configuration registers and loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aim_q    <= '0;
			gain_p_q <= '0;
			gain_i_q <= '0;
			gain_d_q <= '0;
			db_q     <= DEAD_BAND_RST;
			limit_q  <= INT_LIMIT_RST;
			last_q   <= '0;
			prior_q  <= '0;
			fd_q     <= '0;
			acc_q    <= {8'd0, CENTER_RST, {A{1'b0}}};
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_AIM:       aim_q    <= cfg_data;
					REG_GAIN_P:    gain_p_q <= cfg_data;
					REG_GAIN_I:    gain_i_q <= cfg_data;
					REG_GAIN_D:    gain_d_q <= cfg_data;
					REG_DEAD_BAND: db_q     <= cfg_data[7:0];
					REG_INT_LIMIT: limit_q  <= cfg_data;
					REG_CENTER:    acc_q    <= {8'd0, cfg_data, {A{1'b0}}};
					default: ;
				endcase
			end
			if (op == OP_FD) begin
				fd_q <= fd_sat;
			end
			if (op == OP_ACC) begin
				acc_q   <= acc_sat;
				last_q  <= err_q;
				prior_q <= last_q;
			end
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		case (op)
			OP_IDLE: begin
				if (take) begin
					meas_q <= s_axis_tdata;
					seen_q <= s_axis_tuser;
				end
			end
			OP_ERR: err_q <= err_dz;
			OP_MD: begin
				prod_q <= product;
				avg_q  <= avg_cl;
			end
			OP_MP: begin
				sum_q  <= (g_term <<< 1) + (fd_w <<< 1);
				prod_q <= product;
			end
			OP_MI: begin
				sum_q  <= sum_q + fd_w;
				inc_q  <= g_term;
				prod_q <= product;
			end
			OP_DV0: begin
				inc_q <= inc_q + i_term;
				sum_q <= sum_q ^ {W{sum_q[W-1]}};
				neg_q <= sum_q[W-1];
				rem_q <= '0;
				cnt_q <= '0;
			end
			OP_DIV: begin
				sum_q <= {sum_q[W-DIG_W-1:0], qd};
				rem_q <= rem_full[2:0];
				cnt_q <= cnt_q + 1'b1;
			end
			OP_INC: inc_q <= inc_q + fd_w;
			default: ;
		endcase
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (op == OP_OUT && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (op == OP_OUT && out_free) begin
			m_data_q <= {7'd0, err_out, drive};
			m_user_q <= seen_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

endmodule

// ----- src/ipp_seq.sv -----
// Step counter and control store walk for the PID loop.
// Depends on ipp_pkg for the control word, status struct and program.
module ipp_seq import ipp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  seq_stat_t stat,
	output op_t       op
);

	pc_t    pc_q;
	pc_t    pc_d;
	uword_t w;

	assign w = ucode(pc_q);

	// Next step
	always_comb begin
		pc_d = pc_q;
		case (w.jmp)
			J_NEXT: pc_d = pc_q + 1'b1;
			J_TAKE: begin
				if (stat.take) begin
					pc_d = stat.seen ? pc_q + 1'b1 : w.target;
				end
			end
			J_LOOP: pc_d = stat.div_last ? pc_q + 1'b1 : w.target;
			J_OUT: begin
				if (stat.out_free) begin
					pc_d = w.target;
				end
			end
			default: pc_d = PC_IDLE;
		endcase
	end

	// Drive the datapath
	always_comb begin
		op = w.op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule

// ----- src/ipp_check.sv -----
// Port-level assertions for the PID position loop, bound to the top level.
// Depends on ipp_pkg and incremental_pid_position.
module ipp_check import ipp_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic                   s_axis_tuser,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input logic                   m_axis_tuser
);

	// A stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	// A hold item reports a zero error
	a_hold_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[32:16] == 17'd0)
		else $error("hold item carries an error");

	// An accepted item keeps the sequencer busy for the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken twice in a row");

	// A hold item accepted while no result is offered goes through the result step into the result register
	a_hold_lat: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !s_axis_tuser && !m_axis_tvalid
		|=> ##1 m_axis_tvalid)
		else $error("hold item result late");

endmodule

bind incremental_pid_position ipp_check u_ipp_check (.*);

// ----- test/tb_incremental_pid_position.sv -----
// Testbench for incremental_pid_position: stream driver, stream monitor and an in-order
// predictor of the fixed-point PID loop, run through several register settings.
// Depends on ipp_pkg and the RTL of incremental_pid_position.
module tb_incremental_pid_position;
	import ipp_pkg::*;

	localparam int GAIN_FRAC     = 8;
	localparam int ACC_FRAC      = 16;
	localparam int ACC_W         = 24 + ACC_FRAC;
	localparam int DER_W         = 32 + ACC_FRAC;
	localparam int SETTLE_CYCLES = 30;
	localparam int LONG_STALL    = 400;
	localparam int LIMIT_CYCLES  = 400000;
	localparam int PHASES        = 9;
	localparam int PHASE_ITEMS   = 105;

	// Index past the last register, must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic        seen;
		logic [15:0] pos;
	} sensor_item_t;

	typedef struct packed {
		logic [15:0] drive;
		logic        updated;
		logic [16:0] err;
	} loop_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;  // [15:0] measured_position
	logic                   s_axis_tuser = 1'b0; // [0] target_seen
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;       // [15:0] drive_value, [32:16] error_used
	logic                   m_axis_tuser;       // [0] updated
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	// Register shadows
	logic [15:0] aim_reg    = 16'd0;
	logic [15:0] kp_reg     = 16'd0;
	logic [15:0] ki_reg     = 16'd0;
	logic [15:0] kd_reg     = 16'd0;
	logic [7:0]  band_reg   = DEAD_BAND_RST;
	logic [15:0] limit_reg  = INT_LIMIT_RST;

	// Loop state shadows
	longint last_err  = 0;
	longint prior_err = 0;
	longint deriv_f   = 0;
	longint drive_acc = longint'(CENTER_RST) <<< ACC_FRAC;

	sensor_item_t pending_items[$];
	loop_result_t expected_drive[$];
	sensor_item_t next_item;
	loop_result_t want;

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	logic long_stall_req = 1'b0;
	logic long_stall_done;
	int stall_left;

	int mismatch_cnt = 0;
	int items_taken = 0;
	int results_checked = 0;
	int setting_cnt = 0;
	int cycle_cnt = 0;

	incremental_pid_position u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Move a value with 'frac' fraction bits to the accumulator scale, rounding down
	function automatic longint to_acc_scale(longint v, int frac);
		if (ACC_FRAC >= frac)
			return v <<< (ACC_FRAC - frac);
		return v >>> (frac - ACC_FRAC);
	endfunction

	function automatic longint clip_signed(longint v, int width);
		longint hi, lo;
		hi = (longint'(1) <<< (width - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	// Run one control step on the shadows and return the result it shows
	function automatic loop_result_t pid_step(logic seen, logic [15:0] pos);
		longint e, mag, avg2, lim2, diff2, d_new, num, q, p_term, i_term, drv;
		longint aim_l, kp_l, ki_l, kd_l, band_l, lim_l, pos_l;
		loop_result_t r;
		aim_l = aim_reg;
		kp_l = kp_reg;
		ki_l = ki_reg;
		kd_l = kd_reg;
		band_l = band_reg;
		lim_l = limit_reg;
		pos_l = pos;
		e = 0;
		if (seen) begin
			e = pos_l - aim_l;
			mag = (e < 0) ? -e : e;
			if (mag < band_l) e = 0;

			// average kept doubled, clamped to the doubled limit
			avg2 = e + last_err;
			lim2 = lim_l * 2;
			if (avg2 > lim2) avg2 = lim2;
			if (avg2 < -lim2) avg2 = -lim2;

			// derivative filter: floor((2*new + 3*old) / 5)
			diff2 = e - 2 * last_err + prior_err;
			d_new = to_acc_scale(kd_l * diff2, GAIN_FRAC);
			num = 2 * d_new + 3 * deriv_f;
			q = num / 5;
			if (num % 5 < 0) q = q - 1;
			deriv_f = clip_signed(q, DER_W);

			p_term = to_acc_scale(kp_l * (e - last_err), GAIN_FRAC);
			i_term = to_acc_scale(ki_l * avg2, GAIN_FRAC + 1);
			prior_err = last_err;
			last_err = e;
			drive_acc = clip_signed(drive_acc + p_term + i_term + deriv_f, ACC_W);
		end
		drv = drive_acc >>> ACC_FRAC;
		if (drv < 0) drv = 0;
		if (drv > 65535) drv = 65535;
		r.drive = drv[15:0];
		r.updated = seen;
		r.err = e[16:0];
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("MISMATCH at cycle %0d: %s", cycle_cnt, msg);
		mismatch_cnt++;
	endtask

	// Write one register and track it in the shadows
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_AIM:       aim_reg = val;
			REG_GAIN_P:    kp_reg = val;
			REG_GAIN_I:    ki_reg = val;
			REG_GAIN_D:    kd_reg = val;
			REG_DEAD_BAND: band_reg = val[7:0];
			REG_INT_LIMIT: limit_reg = val;
			REG_CENTER:    drive_acc = longint'(val) <<< ACC_FRAC;
			default: ;
		endcase
	endtask

	task automatic push_item(logic seen, logic [15:0] pos);
		pending_items.push_back(sensor_item_t'{seen, pos});
	endtask

	// Hold until every item is through and the block has gone quiet
	task automatic wait_idle();
		while (pending_items.size() != 0 || s_axis_tvalid || expected_drive.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// kind 0: random, 1: low extremes, 2: high extremes
	task automatic load_setting(int kind);
		logic [15:0] gain;
		setting_cnt++;
		case (kind)
			1: begin
				write_reg(REG_AIM, 16'd0);
				write_reg(REG_DEAD_BAND, 16'd0);
				write_reg(REG_INT_LIMIT, 16'd0);
			end
			2: begin
				write_reg(REG_AIM, 16'hFFFF);
				write_reg(REG_DEAD_BAND, 16'h00FF);
				write_reg(REG_INT_LIMIT, 16'hFFFF);
			end
			default: begin
				write_reg(REG_AIM, 16'($urandom_range(65535)));
				write_reg(REG_DEAD_BAND, 16'($urandom_range(3) == 0 ?
					$urandom_range(65535) : $urandom_range(40)));
				write_reg(REG_INT_LIMIT, 16'($urandom_range(3) == 0 ?
					$urandom_range(65535) : $urandom_range(2000)));
			end
		endcase
		// mostly modest gains so the drive does not pin at a rail
		gain = (kind == 2) ? 16'hFFFF : 16'($urandom_range(3) == 0 ?
			$urandom_range(65535) : $urandom_range(700));
		write_reg(REG_GAIN_P, gain);
		gain = (kind == 2) ? 16'hFFFF : 16'($urandom_range(700));
		write_reg(REG_GAIN_I, gain);
		gain = (kind == 2) ? 16'hFFFF : 16'($urandom_range(3) == 0 ?
			$urandom_range(65535) : $urandom_range(700));
		write_reg(REG_GAIN_D, gain);
		if (kind != 0 || $urandom_range(1) == 0)
			write_reg(REG_CENTER, 16'(kind == 1 ? 0 : $urandom_range(65535)));
	endtask

	// Mostly tracking measurements around the aim, with holds and full-range noise
	task automatic queue_random_items(int n);
		int pick, off, p;
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				off = $urandom_range(400);
				p = int'(aim_reg) + off - 200;
				if (p < 0) p = 0;
				if (p > 65535) p = 65535;
				push_item(1'b1, 16'(p));
			end else if (pick < 85) begin
				push_item(1'b0, 16'($urandom_range(65535)));
			end else begin
				push_item(1'b1, 16'($urandom_range(65535)));
			end
		end
	endtask

	// Driver: present pending items, predict each one as it is accepted
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_drive.push_back(pid_step(s_axis_tuser, s_axis_tdata));
				items_taken++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					next_item = pending_items.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= next_item.pos;
					s_axis_tuser <= next_item.seen;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random back-pressure plus one long hold-off on request
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left <= 0;
			long_stall_done <= 1'b0;
		end else if (long_stall_req && !long_stall_done) begin
			stall_left <= LONG_STALL;
			long_stall_done <= 1'b1;
			m_axis_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Monitor: compare each accepted result with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_drive.size() == 0) begin
				report_mismatch($sformatf("result with nothing expected, tdata %h",
					m_axis_tdata));
			end else begin
				want = expected_drive.pop_front();
				results_checked++;
				if (m_axis_tdata[15:0] !== want.drive)
					report_mismatch($sformatf("result %0d drive_value %0d, expected %0d",
						results_checked, m_axis_tdata[15:0], want.drive));
				if (m_axis_tuser !== want.updated)
					report_mismatch($sformatf("result %0d updated %b, expected %b",
						results_checked, m_axis_tuser, want.updated));
				if (m_axis_tdata[32:16] !== want.err)
					report_mismatch($sformatf("result %0d error_used %0d, expected %0d",
						results_checked, $signed(m_axis_tdata[32:16]), $signed(want.err)));
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > LIMIT_CYCLES) begin
			$display("Timeout after %0d cycles, %0d results pending", cycle_cnt,
				expected_drive.size());
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		tx_idle_pct <= 15;
		rx_idle_pct <= 79;

		// Reset values: zero gains hold the drive at the center, deadband of three
		setting_cnt++;
		push_item(1'b0, 16'h1234);
		push_item(1'b1, 16'd0);
		push_item(1'b1, 16'd2);
		push_item(1'b1, 16'd3);
		push_item(1'b1, 16'hFFFF);
		push_item(1'b0, 16'hFFFF);
		wait_idle();

		// Full-scale gains: drive the accumulator to both rails
		setting_cnt++;
		write_reg(REG_UNUSED, 16'hFFFF);
		write_reg(REG_DEAD_BAND, 16'hFF05);
		write_reg(REG_AIM, 16'hFFFF);
		write_reg(REG_GAIN_P, 16'hFFFF);
		write_reg(REG_GAIN_I, 16'hFFFF);
		write_reg(REG_GAIN_D, 16'hFFFF);
		write_reg(REG_INT_LIMIT, 16'hFFFF);
		write_reg(REG_CENTER, 16'd0);
		push_item(1'b1, 16'd0);
		push_item(1'b1, 16'd0);
		push_item(1'b0, 16'd0);
		push_item(1'b1, 16'hFFFF);
		push_item(1'b1, 16'hFFFA);
		push_item(1'b1, 16'hFFFB);
		wait_idle();

		// Wide deadband, zero limit, start at the top rail
		setting_cnt++;
		write_reg(REG_AIM, 16'd32768);
		write_reg(REG_GAIN_P, 16'd256);
		write_reg(REG_GAIN_I, 16'd512);
		write_reg(REG_GAIN_D, 16'd384);
		write_reg(REG_DEAD_BAND, 16'd255);
		write_reg(REG_INT_LIMIT, 16'd0);
		write_reg(REG_CENTER, 16'hFFFF);
		push_item(1'b1, 16'd33022);
		push_item(1'b1, 16'd33023);
		push_item(1'b1, 16'd32513);
		push_item(1'b1, 16'd32514);
		push_item(1'b1, 16'hFFFF);
		push_item(1'b0, 16'h5555);
		push_item(1'b1, 16'd0);
		push_item(1'b1, 16'hAAAA);
		wait_idle();

		// Random phases: three idle patterns, three settings each
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph / 3)
				0: begin
					tx_idle_pct <= 15;
					rx_idle_pct <= 79;
				end
				1: begin
					tx_idle_pct <= 79;
					rx_idle_pct <= 15;
				end
				default: begin
					tx_idle_pct <= 0;
					rx_idle_pct <= 0;
				end
			endcase
			load_setting(ph == 0 ? 1 : (ph == 4 || ph == 8) ? 2 : 0);
			queue_random_items(PHASE_ITEMS);
			if (ph == 6) long_stall_req <= 1'b1;
			wait_idle();
		end

		if (expected_drive.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_drive.size()));
		$display("Run covered %0d items (%0d results checked) over %0d register settings,",
			items_taken, results_checked, setting_cnt);
		$display("with both-side idling and one long output hold-off; %0d mismatches",
			mismatch_cnt);
		if (mismatch_cnt == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
